>>> hw/rtl/wtsf_pkg.sv
// Package of shared types and constants for the wavetable SysEx framer.
`timescale 1ns / 1ps

package wtsf_pkg;

  localparam int unsigned SAMPLES_PER_WAVE = 128;
  localparam int unsigned WAVES_PER_TABLE  = 64;
  localparam int unsigned QUEUE_DEPTH      = 4;

  localparam int unsigned SAMPLE_W = 21;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned WAVE_W   = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SEVEN_W  = 7;
  localparam int unsigned NAME_HI_W = 56;
  localparam int unsigned NAME_LO_W = 42;
  localparam int unsigned NAME_CHARS = 14;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 56;

  localparam logic [BYTE_W-1:0] MSG_START = 8'hf0;
  localparam logic [BYTE_W-1:0] MAKER_ID  = 8'h3e;
  localparam logic [BYTE_W-1:0] MODEL_ID  = 8'h13;
  localparam logic [BYTE_W-1:0] DEVICE_ID = 8'h00;
  localparam logic [BYTE_W-1:0] DUMP_CMD  = 8'h12;
  localparam logic [BYTE_W-1:0] MSG_END   = 8'hf7;
  localparam logic [SEVEN_W-1:0] SLOT_RESET = 7'd80;

  // Byte indices within each phase of a request: the last index of each phase and the trailer fields.
  localparam logic [CNT_W-1:0] HEAD_LAST   = 5'd7;
  localparam logic [CNT_W-1:0] SAMPLE_LAST = 5'd2;
  localparam logic [CNT_W-1:0] TAIL_NAME_END = 5'd13;
  localparam logic [CNT_W-1:0] TAIL_RSV0   = 5'd14;
  localparam logic [CNT_W-1:0] TAIL_RSV1   = 5'd15;
  localparam logic [CNT_W-1:0] TAIL_SUM    = 5'd16;
  localparam logic [CNT_W-1:0] TAIL_LAST   = 5'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT      = 2'd0,
    CFG_NAME_HI   = 2'd1,
    CFG_NAME_LO   = 2'd2,
    CFG_SKIP      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_SAMPLE,
    PH_TAIL
  } phase_e;

  // One classified sample waiting for the byte sequencer.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                first;
    logic                last;
    logic [WAVE_W-1:0]   wave;
  } entry_t;

  // Settings the byte sequencer reads.
  typedef struct packed {
    logic [SEVEN_W-1:0]   slot;
    logic [NAME_HI_W-1:0] name_hi;
    logic [NAME_LO_W-1:0] name_lo;
  } msg_cfg_t;

endpackage

>>> hw/rtl/wavetable_sysex_framer.sv
// Top level of the wavetable SysEx framer: settings registers, the request queue and the two halves.
`timescale 1ns / 1ps

// This block turns a stream of signed 21-bit wavetable samples into MIDI
// SysEx wave dumps, one 410-byte message for every 128 samples used. Each
// message is the header F0 3E 13 00 12, the slot, the wave number and a
// format byte of zero; then three 7-bit bytes per sample (bits 20..14,
// 13..7 and 6..0); then the 14 name characters, two reserved zeros, a 7-bit
// checksum and F7. The wave number wraps after 64 waves. With skip mode on,
// every second sample request is taken and discarded. Bytes leave at one per
// clock, unless out_stall_i holds them, through a registered output; a sample
// gives three bytes, and the first and last sample of a wave also carry the
// header and trailer, which share the same byte sequencer. A four-deep request
// queue sits between the sample classifier and the sequencer, so samples are
// taken while earlier bytes are still going out, and in_stall_o rises only
// when that queue is full. The out_byte_o request carries run_last_o on the
// final byte produced by a sample and message_end_o on the closing F7. The
// settings port takes writes at any time (cfg_ready_o is always high), but
// they must be made only while the block is idle; slot and name are read as
// the header and trailer bytes are produced.
module wavetable_sysex_framer
  import wtsf_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_W-1:0]    sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [BYTE_W-1:0]             out_byte_o,
  output logic                          run_last_o,
  output logic                          message_end_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  logic [SEVEN_W-1:0]   slot_q;
  logic [NAME_HI_W-1:0] name_hi_q;
  logic [NAME_LO_W-1:0] name_lo_q;
  logic                 skip_q;
  logic                 cfg_we;
  msg_cfg_t             msg_cfg;
  entry_t               push_data, head;
  logic                 push, full, pop, empty;

  // The settings port never holds off a write.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= SLOT_RESET;
      name_hi_q <= '0;
      name_lo_q <= '0;
      skip_q    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SLOT:    slot_q    <= cfg_data_i[SEVEN_W-1:0];
        CFG_NAME_HI: name_hi_q <= cfg_data_i[NAME_HI_W-1:0];
        CFG_NAME_LO: name_lo_q <= cfg_data_i[NAME_LO_W-1:0];
        CFG_SKIP:    skip_q    <= cfg_data_i[0];
        default:     skip_q    <= skip_q;
      endcase
    end
  end

  assign msg_cfg.slot    = slot_q;
  assign msg_cfg.name_hi = name_hi_q;
  assign msg_cfg.name_lo = name_lo_q;

  // Front half: takes sample requests, applies skip mode and marks the first
  // and last sample of each wave together with its wave number.
  wtsf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_value_i   (sample_value_i),
    .skip_alternate_i (skip_q),
    .q_full_i         (full),
    .q_push_o         (push),
    .q_data_o         (push_data)
  );

  wtsf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // Back half: walks each queued sample through header, sample and trailer
  // bytes, keeping the running checksum.
  wtsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (empty),
    .q_head_i      (head),
    .q_pop_o       (pop),
    .cfg_i         (msg_cfg),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

endmodule

>>> hw/rtl/wtsf_queue.sv
// Small request queue between the sample classifier and the byte sequencer.
`timescale 1ns / 1ps

module wtsf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wtsf_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output wtsf_pkg::entry_t head_o
);
  import wtsf_pkg::*;

  entry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

>>> hw/rtl/wtsf_front.sv
// Sample classifier: drops skipped samples and tracks position within the wave.
`timescale 1ns / 1ps

module wtsf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [wtsf_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                            skip_alternate_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output wtsf_pkg::entry_t                q_data_o
);
  import wtsf_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [WAVE_W-1:0] wave_q, wave_d;
  logic              skip_phase_q, skip_phase_d;
  logic              accept, drop, is_last;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign drop       = skip_alternate_i && skip_phase_q;
  assign is_last    = (pos_q == POS_W'(SAMPLES_PER_WAVE - 1));

  assign q_push_o        = accept && !drop;
  assign q_data_o.sample = sample_value_i;
  assign q_data_o.first  = (pos_q == '0);
  assign q_data_o.last   = is_last;
  assign q_data_o.wave   = wave_q;

  always_comb begin
    pos_d        = pos_q;
    wave_d       = wave_q;
    skip_phase_d = skip_phase_q;
    if (accept) begin
      if (drop) begin
        skip_phase_d = 1'b0;
      end else begin
        skip_phase_d = skip_alternate_i;
        if (is_last) begin
          pos_d  = '0;
          wave_d = (wave_q == WAVE_W'(WAVES_PER_TABLE - 1)) ? '0 : wave_q + WAVE_W'(1);
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      wave_q       <= '0;
      skip_phase_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      wave_q       <= wave_d;
      skip_phase_q <= skip_phase_d;
    end
  end

endmodule

>>> hw/rtl/wtsf_back.sv
// Byte sequencer: expands queued requests into SysEx bytes with checksum.
`timescale 1ns / 1ps

module wtsf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  wtsf_pkg::entry_t              q_head_i,
  output logic                          q_pop_o,
  input  wtsf_pkg::msg_cfg_t            cfg_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wtsf_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          run_last_o,
  output logic                          message_end_o
);
  import wtsf_pkg::*;

  phase_e             phase_q, phase_d, eff_phase;
  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, eff_cnt;
  logic [SEVEN_W-1:0] sum_q, sum_d;
  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  out_byte_q;
  logic               run_last_q, msg_end_q;
  logic               adv, done, summed, clear_sum, is_end;
  logic [BYTE_W-1:0]  byte_val;
  logic [SEVEN_W-1:0] name_chars [NAME_CHARS];

  assign adv       = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign eff_phase = busy_q ? phase_q : (q_head_i.first ? PH_HEAD : PH_SAMPLE);
  assign eff_cnt   = busy_q ? cnt_q : '0;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      name_chars[i] = cfg_i.name_hi[SEVEN_W*i +: SEVEN_W];
    end
    for (int i = 0; i < 6; i++) begin
      name_chars[8+i] = cfg_i.name_lo[SEVEN_W*i +: SEVEN_W];
    end
  end

  // Next state of the sequencer.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done    = 1'b0;
    unique case (eff_phase)
      PH_HEAD: begin
        if (eff_cnt == HEAD_LAST) begin
          phase_d = PH_SAMPLE;
          cnt_d   = '0;
        end else begin
          phase_d = PH_HEAD;
          cnt_d   = eff_cnt + CNT_W'(1);
        end
      end
      PH_SAMPLE: begin
        if (eff_cnt == SAMPLE_LAST) begin
          phase_d = PH_TAIL;
          cnt_d   = '0;
          done    = !q_head_i.last;
        end else begin
          phase_d = PH_SAMPLE;
          cnt_d   = eff_cnt + CNT_W'(1);
        end
      end
      PH_TAIL: begin
        phase_d = PH_TAIL;
        cnt_d   = eff_cnt + CNT_W'(1);
        done    = (eff_cnt == TAIL_LAST);
      end
      default: begin
        phase_d = PH_HEAD;
        cnt_d   = '0;
      end
    endcase
    if (!adv) begin
      phase_d = phase_q;
      cnt_d   = cnt_q;
      done    = 1'b0;
    end else begin
      busy_d = !done;
    end
  end

  // Byte produced in the current step.
  always_comb begin
    byte_val  = '0;
    summed    = 1'b0;
    clear_sum = 1'b0;
    is_end    = 1'b0;
    unique case (eff_phase)
      PH_HEAD: begin
        unique case (eff_cnt[2:0])
          3'd0: byte_val = MSG_START;
          3'd1: byte_val = MAKER_ID;
          3'd2: byte_val = MODEL_ID;
          3'd3: byte_val = DEVICE_ID;
          3'd4: byte_val = DUMP_CMD;
          3'd5: byte_val = {1'b0, cfg_i.slot};
          3'd6: byte_val = BYTE_W'(q_head_i.wave);
          default: clear_sum = 1'b1;
        endcase
      end
      PH_SAMPLE: begin
        summed = 1'b1;
        unique case (eff_cnt[1:0])
          2'd0:    byte_val = {1'b0, q_head_i.sample[20:14]};
          2'd1:    byte_val = {1'b0, q_head_i.sample[13:7]};
          default: byte_val = {1'b0, q_head_i.sample[6:0]};
        endcase
      end
      PH_TAIL: begin
        if (eff_cnt <= TAIL_NAME_END) begin
          byte_val = {1'b0, name_chars[eff_cnt[3:0]]};
          summed   = 1'b1;
        end else if (eff_cnt == TAIL_RSV0 || eff_cnt == TAIL_RSV1) begin
          byte_val = '0;
        end else if (eff_cnt == TAIL_SUM) begin
          byte_val = {1'b0, sum_q};
        end else begin
          byte_val = MSG_END;
          is_end   = 1'b1;
        end
      end
      default: byte_val = '0;
    endcase
  end

  always_comb begin
    sum_d = sum_q;
    if (adv) begin
      if (clear_sum) begin
        sum_d = '0;
      end else if (summed) begin
        sum_d = sum_q + byte_val[SEVEN_W-1:0];
      end
    end
    out_valid_d = adv ? 1'b1 : (out_valid_q && out_stall_i);
  end

  assign q_pop_o = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= byte_val;
      run_last_q <= done;
      msg_end_q  <= is_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign message_end_o = msg_end_q;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && msg_end_q) |-> run_last_q)
    else $error("closing byte not flagged as last of its request");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("request retired from an empty queue");
  a_busy_has_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !q_empty_i)
    else $error("sequencer mid-request without a queued request");
`endif

endmodule
